// ===== rtl/itie_pkg.sv =====
// ----------------------------------------------------------------------------
// itie_pkg: shared types and constants
// Command codes, field widths and reset values for the image eviction block.
// ----------------------------------------------------------------------------
package itie_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int EVICT_LIMIT_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int SIZE_W  = 24;
  localparam int OTHER_W = 32;
  localparam int MASK_W  = 16;
  localparam int TOTAL_W = 29;
  localparam int CAP_W   = 32;
  localparam int TIMER_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IDLE = 1'd1;

  localparam logic [CAP_W-1:0]   CAPACITY_RST = 32'd67108864;
  localparam logic [TIMER_W-1:0] MAX_IDLE_RST = 8'd120;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  slot;
    logic [SIZE_W-1:0]  image_size;
    logic [OTHER_W-1:0] other_usage;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0]  evicted_mask;
    logic [TOTAL_W-1:0] image_bytes_used;
    logic               pressure_mode;
    logic               status;
  } out_item_t;

endpackage

// ===== rtl/itie_stream_if.sv =====
// ----------------------------------------------------------------------------
// itie_stream_if: valid/ready channel
// Carries one payload of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface itie_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/itie_entry_ram.sv =====
// ----------------------------------------------------------------------------
// itie_entry_ram: entry table memory
// Holds timer and size per slot; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module itie_entry_ram
  import itie_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  logic [TIMER_W-1:0]  wtimer,
  input  logic [SIZE_W-1:0]   wsize,
  input  logic [IDX_W-1:0]    raddr,
  output logic [TIMER_W-1:0]  rtimer,
  output logic [SIZE_W-1:0]   rsize
);

  logic [TIMER_W+SIZE_W-1:0] mem [ENTRIES];
  logic [TIMER_W+SIZE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wtimer, wsize};
    end
    rdata_r <= mem[raddr];
  end

  assign rtimer = rdata_r[TIMER_W+SIZE_W-1:SIZE_W];
  assign rsize  = rdata_r[SIZE_W-1:0];

endmodule

// ===== rtl/idle_timer_image_eviction.sv =====
// ----------------------------------------------------------------------------
// idle_timer_image_eviction: idle-timer image cache eviction
// Load, touch, free and frame-tick requests on a table of cached images.
// ----------------------------------------------------------------------------
// Sequence: load/touch/free read the slot, then update and output; a relaxed
//   tick runs check, a scan of all entries and output; a pressured tick repeats
//   eviction passes (scan, drop, recheck), at most EVICT_LIMIT passes, then output.
//   The single read port of the entry RAM sets the pace.
// Throughput: one request at a time; the next is taken once the result leaves
//   the output register (or together with its departure).
// Reset: valid bits, total, state and config registers return to reset values; the
//   entry RAM needs no clearing since entries are read only when valid.
// ----------------------------------------------------------------------------
module idle_timer_image_eviction
  import itie_pkg::*;
#(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int EVICT_LIMIT = EVICT_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  itie_stream_if.sink           in_ch,
  itie_stream_if.source         out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int EVC_W = $clog2(EVICT_LIMIT + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);
  localparam logic [EVC_W-1:0] EVC_MAX  = EVC_W'(EVICT_LIMIT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SLOT  = 3'd1;  // single-slot read in flight
  localparam logic [2:0] ST_SCAN  = 3'd2;  // sweep entries
  localparam logic [2:0] ST_CHECK = 3'd3;  // pressure or relief compare
  localparam logic [2:0] ST_DROP  = 3'd4;  // apply chosen eviction
  localparam logic [2:0] ST_OUT   = 3'd5;

  // Registers
  logic [2:0]          state_r, state_nxt;
  logic [CAP_W-1:0]    cap_r;
  logic [TIMER_W-1:0]  max_idle_r;
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  in_item_t            req_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;       // read address counter
  logic                rd_v_r;               // ram data valid this cycle
  logic [IDX_W-1:0]    rd_idx_r;             // which entry the ram data is
  logic                pressure_r, pressure_nxt;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    best_r, best_nxt;
  logic [TIMER_W-1:0]  best_t_r, best_t_nxt;
  logic [SIZE_W-1:0]   best_sz_r, best_sz_nxt;
  logic [EVC_W-1:0]    done_r, done_nxt;
  logic [MASK_W-1:0]   mask_r, mask_nxt;
  logic                status_r, status_nxt;
  logic                out_v_r;
  logic                first_r, first_nxt;   // first compare of a tick

  // Compare logic: usage sum and multiplied compares, both combinational
  logic [CAP_W:0]      usage;
  logic                above80, above50;

  // RAM ports
  logic                we;
  logic [IDX_W-1:0]    waddr, raddr;
  logic [TIMER_W-1:0]  wtimer, rtimer;
  logic [SIZE_W-1:0]   wsize, rsize;

  itie_entry_ram #(.ENTRIES(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wtimer(wtimer), .wsize(wsize),
    .raddr(raddr), .rtimer(rtimer), .rsize(rsize)
  );

  wire in_fire  = in_ch.valid & in_ch.ready;
  wire out_fire = out_ch.valid & out_ch.ready;
  wire slot_ok  = (32'(req_r.slot) < ENTRIES);
  wire [IDX_W-1:0] req_idx = IDX_W'(req_r.slot);

  assign in_ch.ready  = (state_r == ST_IDLE) && (!out_v_r || out_ch.ready);
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = '{evicted_mask: mask_r, image_bytes_used: total_r,
                          pressure_mode: pressure_r, status: status_r};

  // usage = total + other fits 33 bits; x5 and x4 compares stay narrow
  assign usage   = {4'd0, total_r} + {1'b0, req_r.other_usage};
  assign above80 = ({usage, 2'b00} + {2'b00, usage}) > {1'b0, cap_r, 2'b00};
  assign above50 = {usage, 1'b0} > {2'b00, cap_r};

  // Drop helper for the total
  function automatic logic [TOTAL_W-1:0] sub_sat(logic [TOTAL_W-1:0] t,
                                                 logic [SIZE_W-1:0] s);
    logic [TOTAL_W-1:0] se;
    se = TOTAL_W'(s);
    sub_sat = (t >= se) ? (t - se) : '0;
  endfunction

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    total_nxt    = total_r;
    cnt_nxt      = cnt_r;
    pressure_nxt = pressure_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_t_nxt   = best_t_r;
    best_sz_nxt  = best_sz_r;
    done_nxt     = done_r;
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    first_nxt    = first_r;
    we           = 1'b0;
    waddr        = rd_idx_r;
    wtimer       = rtimer;
    wsize        = rsize;
    raddr        = cnt_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        raddr = IDX_W'(in_ch.data.slot);
        if (in_fire) begin
          mask_nxt     = '0;
          status_nxt   = 1'b0;
          pressure_nxt = 1'b0;
          done_nxt     = '0;
          cnt_nxt      = '0;
          first_nxt    = 1'b1;
          state_nxt    = (in_ch.data.command == CMD_TICK) ? ST_CHECK : ST_SLOT;
        end
      end
      ST_SLOT: begin
        // The slot was read at the accepting edge; its data is on the RAM output.
        state_nxt = ST_OUT;
        if (!slot_ok || ((req_r.command == CMD_LOAD) == valid_r[req_idx])) begin
          status_nxt = 1'b1;
        end else begin
          unique case (req_r.command)
            CMD_LOAD: begin
              valid_nxt[req_idx] = 1'b1;
              we = 1'b1; waddr = req_idx; wtimer = max_idle_r;
              wsize = req_r.image_size;
              total_nxt = ({1'b0, total_r} + (TOTAL_W+1)'(req_r.image_size) >
                           {1'b0, TOTAL_MAX}) ? TOTAL_MAX
                          : total_r + TOTAL_W'(req_r.image_size);
            end
            CMD_TOUCH: begin
              // Reload the timer, keep the stored size.
              we = 1'b1; waddr = req_idx; wtimer = max_idle_r; wsize = rsize;
            end
            default: begin
              valid_nxt[req_idx] = 1'b0;
              total_nxt = sub_sat(total_r, rsize);
              mask_nxt  = mask_r | (MASK_W'(1) << req_idx);
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (first_r) begin
          first_nxt = 1'b0;
          pressure_nxt = above80;
          if (!above80) begin
            state_nxt = ST_SCAN;
          end else if (!above50) begin
            state_nxt = ST_OUT;
          end else begin
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end
        end else if (done_r == EVC_MAX || !above50) begin
          state_nxt = ST_OUT;
        end else begin
          found_nxt = 1'b0;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue reads 0..ENTRIES-1; the data returns in the cycle after each read.
        if (cnt_r != LAST_CNT) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rd_v_r && valid_r[rd_idx_r]) begin
          if (!pressure_r) begin
            if (rtimer == '0) begin
              valid_nxt[rd_idx_r] = 1'b0;
              total_nxt = sub_sat(total_r, rsize);
              mask_nxt  = mask_r | (MASK_W'(1) << rd_idx_r);
            end else begin
              we = 1'b1; wtimer = rtimer - 1'b1;
            end
          end else if (rtimer != max_idle_r &&
                       (!found_r || rtimer < best_t_r)) begin
            found_nxt   = 1'b1;
            best_nxt    = rd_idx_r;
            best_t_nxt  = rtimer;
            best_sz_nxt = rsize;
          end
        end
        if (!rd_v_r && cnt_r == LAST_CNT) begin
          cnt_nxt   = '0;
          state_nxt = !pressure_r ? ST_OUT : (found_nxt ? ST_DROP : ST_OUT);
        end
      end
      ST_DROP: begin
        // Evict the chosen entry, then recheck the relief threshold.
        valid_nxt[best_r] = 1'b0;
        total_nxt = sub_sat(total_r, best_sz_r);
        mask_nxt  = mask_r | (MASK_W'(1) << best_r);
        done_nxt  = done_r + 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cap_r      <= CAPACITY_RST;
      max_idle_r <= MAX_IDLE_RST;
      valid_r    <= '0;
      total_r    <= '0;
      out_v_r    <= 1'b0;
      rd_v_r     <= 1'b0;
      cnt_r      <= '0;
      done_r     <= '0;
      first_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
      first_r <= first_nxt;
      rd_v_r  <= (state_r == ST_SCAN) && (cnt_r != LAST_CNT);
      if (cfg_we && cfg_index == REG_CAPACITY) cap_r <= cfg_data;
      if (cfg_we && cfg_index == REG_MAX_IDLE) max_idle_r <= cfg_data[TIMER_W-1:0];
      // Hold the result until taken; raise it when a request finishes.
      if (state_r == ST_OUT) begin
        out_v_r <= 1'b1;
      end else if (out_fire) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= cnt_r[IDX_W-1:0];
    pressure_r <= pressure_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    best_t_r   <= best_t_nxt;
    best_sz_r  <= best_sz_nxt;
    mask_r     <= mask_nxt;
    status_r   <= status_nxt;
    if (in_fire) req_r <= in_ch.data;
  end

`ifndef ASSERT_OFF
  a_evict_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r <= EVC_MAX)
    else $error("eviction count past limit");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("request taken while busy");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> !out_v_r || out_ch.ready)
    else $error("result overwritten before taken");
  a_pressure_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && pressure_r |-> req_r.command == CMD_TICK)
    else $error("pressure flag on non-tick request");
`endif

endmodule
